@@ src/hpid_pkg.sv @@
// Shared widths, codes and reset values for the heading PID turn controller.
package hpid_pkg;

	localparam int HEADING_W  = 24;
	localparam int ERR_W      = 25;
	localparam int DERIV_W    = 26;
	localparam int SUM_W      = 40;
	localparam int TICK_W     = 17;
	localparam int GAIN_W     = 16;
	localparam int POWER_W    = 15;
	localparam int LIMIT_W    = 16;
	localparam int MODE_W     = 4;
	localparam int DRIVE_W    = 16;
	localparam int ACT_W      = 2;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int M_TDATA_W  = 40;

	// mode register bits
	localparam int MODE_PIVOT      = 0;
	localparam int MODE_RIGHT_HOLD = 1;
	localparam int MODE_LEFT_HOLD  = 2;
	localparam int MODE_STILL      = 3;

	localparam logic [ERR_W-1:0]   SETTLE_ERR  = ERR_W'(512);
	localparam logic [DERIV_W-1:0] STILL_DERIV = DERIV_W'(256);
	localparam logic [TICK_W-1:0]  TICK_MAX    = '1;
	localparam int PIVOT_KP = 54;
	localparam int PIVOT_KI = 20;

	localparam logic [HEADING_W-1:0] RST_TARGET     = '0;
	localparam logic [GAIN_W-1:0]    RST_GAIN_P     = GAIN_W'(234);
	localparam logic [GAIN_W-1:0]    RST_GAIN_I     = '0;
	localparam logic [GAIN_W-1:0]    RST_GAIN_D     = GAIN_W'(1101);
	localparam logic [GAIN_W-1:0]    RST_GAIN_FF    = '0;
	localparam logic [POWER_W-1:0]   RST_MAX_POWER  = POWER_W'(3072);
	localparam logic [LIMIT_W-1:0]   RST_TIME_LIMIT = LIMIT_W'(300);
	localparam logic [MODE_W-1:0]    RST_MODE       = MODE_W'(14);

	typedef enum logic [STATUS_W-1:0] {
		ST_RUN     = 2'd0,
		ST_SETTLED = 2'd1,
		ST_TIMEOUT = 2'd2,
		ST_IDLE    = 2'd3
	} status_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_SPIN = 2'd0,
		ACT_HOLD = 2'd1,
		ACT_KEEP = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET     = 3'd0,
		REG_GAIN_P     = 3'd1,
		REG_GAIN_I     = 3'd2,
		REG_GAIN_D     = 3'd3,
		REG_GAIN_FF    = 3'd4,
		REG_MAX_POWER  = 3'd5,
		REG_TIME_LIMIT = 3'd6,
		REG_MODE       = 3'd7
	} cfg_reg_t;

endpackage

@@ src/heading_pid_turn_controller.sv @@
// Heading PID turn controller: five-stage pipeline from heading sample to drive commands.
//
// One heading sample enters on the slave stream (tdata = heading, tuser =
// start_req) and one result leaves on the master stream: tdata holds left and
// right drive and both side actions, tuser holds the status. Configuration
// registers are written through cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high and a write lands at the edge it is presented.
// A new sample can be taken every cycle unless a stalled receiver holds the
// pipeline. Turn state (integral, previous error, derivative, tick count,
// start heading) is updated as a sample leaves the input register, so
// back-to-back samples see each other's updates; the multiplies and sums
// behind it follow in three registered stages, the error_sum by gain_i
// product split at bit 24. Each stage holds its item while the next one is
// full and cannot load, so the input keeps accepting until all five
// registers are occupied by a stalled receiver.
// Reset (arst_n low) clears all valid flags and turn state, leaves the block
// idle and loads the default gains, limits and mode.
module heading_pid_turn_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [hpid_pkg::HEADING_W-1:0]    s_axis_tdata,   // [23:0] heading
	input  logic                              s_axis_tuser,   // [0] start_req
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [15:0] left_drive, [31:16] right_drive, [33:32] left_action,
	// [35:34] right_action, [39:36] zero
	output logic [hpid_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	output logic [hpid_pkg::STATUS_W-1:0]     m_axis_tuser,   // [1:0] status
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hpid_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hpid_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import hpid_pkg::*;

	// configuration
	logic signed [HEADING_W-1:0] target_q;
	logic [GAIN_W-1:0]           gain_p_q, gain_i_q, gain_d_q, gain_ff_q;
	logic [POWER_W-1:0]          max_power_q;
	logic [LIMIT_W-1:0]          time_limit_q;
	logic [MODE_W-1:0]           mode_q;

	// turn state
	logic signed [ERR_W-1:0]     prev_error_q;
	logic signed [DERIV_W-1:0]   last_deriv_q;
	logic signed [SUM_W-1:0]     error_sum_q;
	logic signed [HEADING_W-1:0] start_heading_q;
	logic [TICK_W-1:0]           tick_q;
	logic                        running_q;

	// pipeline
	logic                        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                        ld2, ld3, ld4, ld5;
	logic                        start_s1;
	logic signed [HEADING_W-1:0] heading_s1;

	status_t                     kind_s2, kind_s3, kind_s4;
	logic signed [ERR_W-1:0]     err_s2;
	logic signed [DERIV_W-1:0]   deriv_s2;
	logic signed [SUM_W-1:0]     sum_s2;
	logic signed [ERR_W-1:0]     ffd_s2;

	logic signed [41:0]          pe_s3;
	logic signed [42:0]          pd_s3;
	logic signed [41:0]          pf_s3;
	logic [39:0]                 pil_s3;
	logic signed [32:0]          pih_s3;
	logic signed [45:0]          pv_s3, pv_s4;

	logic signed [43:0]          acc_a_s4;
	logic signed [56:0]          acc_b_s4;

	logic signed [DRIVE_W-1:0]   left_s5, right_s5;
	action_t                     left_act_s5, right_act_s5;
	status_t                     status_s5;

	// ---------------------------------------------------------------
	// configuration port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= RST_TARGET;
			gain_p_q     <= RST_GAIN_P;
			gain_i_q     <= RST_GAIN_I;
			gain_d_q     <= RST_GAIN_D;
			gain_ff_q    <= RST_GAIN_FF;
			max_power_q  <= RST_MAX_POWER;
			time_limit_q <= RST_TIME_LIMIT;
			mode_q       <= RST_MODE;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TARGET:     target_q     <= $signed(cfg_data[HEADING_W-1:0]);
				REG_GAIN_P:     gain_p_q     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:     gain_i_q     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:     gain_d_q     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_FF:    gain_ff_q    <= cfg_data[GAIN_W-1:0];
				REG_MAX_POWER:  max_power_q  <= cfg_data[POWER_W-1:0];
				REG_TIME_LIMIT: time_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_MODE:       mode_q       <= cfg_data[MODE_W-1:0];
			endcase
		end
	end

	// ---------------------------------------------------------------
	// stage handshake: a stage loads when empty or when its content moves on
	assign ld5           = !vld_s5 || m_axis_tready;
	assign ld4           = !vld_s4 || ld5;
	assign ld3           = !vld_s3 || ld4;
	assign ld2           = !vld_s2 || ld3;
	assign s_axis_tready = !vld_s1 || ld2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (s_axis_tready) vld_s1 <= s_axis_tvalid;
			if (ld2)           vld_s2 <= vld_s1;
			if (ld3)           vld_s3 <= vld_s2;
			if (ld4)           vld_s4 <= vld_s3;
			if (ld5)           vld_s5 <= vld_s4;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			start_s1   <= s_axis_tuser;
			heading_s1 <= $signed(s_axis_tdata);
		end
	end

	// ---------------------------------------------------------------
	// turn decision and state update
	logic                        run_eff, timed_out, settle, sum_clr, sum_ovf;
	logic [TICK_W-1:0]           tick_eff, tick_next;
	logic signed [HEADING_W-1:0] start_eff;
	logic signed [ERR_W-1:0]     err_c, ffd_c;
	logic [ERR_W-1:0]            err_mag;
	logic signed [DERIV_W-1:0]   deriv_c;
	logic [DERIV_W-1:0]          last_deriv_mag;
	logic [SUM_W-1:0]            sum_mag;
	logic signed [SUM_W-1:0]     sum_base, sum_c;
	logic signed [SUM_W:0]       sum_wide;
	status_t                     kind_c;
	logic                        upd;

	assign run_eff   = start_s1 || running_q;
	assign tick_eff  = start_s1 ? '0 : tick_q;
	assign start_eff = start_s1 ? heading_s1 : start_heading_q;
	assign timed_out = tick_eff > {1'b0, time_limit_q};
	assign tick_next = (tick_eff == TICK_MAX) ? tick_eff : tick_eff + 1'b1;

	assign err_c          = ERR_W'(target_q) - ERR_W'(heading_s1);
	assign ffd_c          = ERR_W'(target_q) - ERR_W'(start_eff);
	assign err_mag        = err_c[ERR_W-1] ? ERR_W'(-err_c) : err_c;
	assign last_deriv_mag = last_deriv_q[DERIV_W-1] ? DERIV_W'(-last_deriv_q) : last_deriv_q;
	assign settle         = (err_mag < SETTLE_ERR)
	                     && (!mode_q[MODE_STILL] || last_deriv_mag < STILL_DERIV);
	assign deriv_c        = DERIV_W'(err_c) - DERIV_W'(prev_error_q);

	// integral: restart on zero error or when the error is under the running sum
	assign sum_mag  = error_sum_q[SUM_W-1] ? SUM_W'(-error_sum_q) : error_sum_q;
	assign sum_clr  = (err_c == '0) || (SUM_W'(err_mag) < sum_mag);
	assign sum_base = sum_clr ? '0 : error_sum_q;
	assign sum_wide = (SUM_W+1)'(sum_base) + (SUM_W+1)'(err_c);
	assign sum_ovf  = sum_wide[SUM_W] != sum_wide[SUM_W-1];

	always_comb begin
		if (sum_ovf) begin
			sum_c = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_c = sum_wide[SUM_W-1:0];
		end
	end

	always_comb begin
		priority if (!run_eff) begin
			kind_c = ST_IDLE;
		end else if (timed_out) begin
			kind_c = ST_TIMEOUT;
		end else if (settle) begin
			kind_c = ST_SETTLED;
		end else begin
			kind_c = ST_RUN;
		end
	end

	assign upd = vld_s1 && ld2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q    <= '0;
			last_deriv_q    <= '0;
			error_sum_q     <= '0;
			start_heading_q <= '0;
			tick_q          <= '0;
			running_q       <= 1'b0;
		end else if (upd) begin
			start_heading_q <= start_eff;
			unique case (kind_c)
				ST_IDLE: begin
				end
				ST_TIMEOUT, ST_SETTLED: begin
					running_q <= 1'b0;
					tick_q    <= tick_eff;
				end
				ST_RUN: begin
					running_q    <= 1'b1;
					tick_q       <= tick_next;
					prev_error_q <= err_c;
					last_deriv_q <= deriv_c;
					error_sum_q  <= sum_c;
				end
			endcase
		end
	end

	// stage 2
	always_ff @(posedge clk) begin
		if (ld2) begin
			kind_s2  <= kind_c;
			err_s2   <= err_c;
			deriv_s2 <= deriv_c;
			sum_s2   <= sum_c;
			ffd_s2   <= ffd_c;
		end
	end

	// stage 3: products; integral term split at bit 24
	always_ff @(posedge clk) begin
		if (ld3) begin
			kind_s3 <= kind_s2;
			pe_s3   <= err_s2 * $signed({1'b0, gain_p_q});
			pd_s3   <= deriv_s2 * $signed({1'b0, gain_d_q});
			pf_s3   <= ffd_s2 * $signed({1'b0, gain_ff_q});
			pil_s3  <= sum_s2[23:0] * gain_i_q;
			pih_s3  <= $signed(sum_s2[SUM_W-1:24]) * $signed({1'b0, gain_i_q});
			pv_s3   <= 46'(sum_s2) * $signed(46'(PIVOT_KI))
			         + 46'(err_s2) * $signed(46'(PIVOT_KP));
		end
	end

	// stage 4: partial sums
	always_ff @(posedge clk) begin
		if (ld4) begin
			kind_s4  <= kind_s3;
			acc_a_s4 <= 44'(pe_s3) + 44'(pd_s3) + 44'(pf_s3);
			acc_b_s4 <= $signed({pih_s3, 24'b0}) + $signed({17'b0, pil_s3});
			pv_s4    <= pv_s3;
		end
	end

	// stage 5: floor to Q.8, clamp, drive commands
	logic signed [57:0]          acc_c;
	logic signed [49:0]          pw_n;
	logic signed [49:0]          mp_c;
	logic signed [37:0]          pw_v;
	logic signed [DRIVE_W-1:0]   pow_n, pow_v;
	logic signed [DRIVE_W-1:0]   left_c, right_c;
	action_t                     left_act_c, right_act_c;

	assign acc_c = 58'(acc_a_s4) + 58'(acc_b_s4);
	assign pw_n  = 50'(acc_c >>> 8);
	assign mp_c  = $signed({35'b0, max_power_q});
	assign pw_v  = 38'(pv_s4 >>> 8);

	always_comb begin
		priority if (pw_n > mp_c) begin
			pow_n = DRIVE_W'(mp_c);
		end else if (pw_n < -mp_c) begin
			pow_n = DRIVE_W'(-mp_c);
		end else begin
			pow_n = DRIVE_W'(pw_n);
		end
	end

	always_comb begin
		priority if (pw_v > 38'sd32767) begin
			pow_v = 16'sh7fff;
		end else if (pw_v < -38'sd32768) begin
			pow_v = 16'sh8000;
		end else begin
			pow_v = DRIVE_W'(pw_v);
		end
	end

	always_comb begin
		left_c      = '0;
		right_c     = '0;
		left_act_c  = ACT_KEEP;
		right_act_c = ACT_KEEP;
		unique case (kind_s4)
			ST_IDLE: begin
			end
			ST_TIMEOUT, ST_SETTLED: begin
				left_act_c  = ACT_HOLD;
				right_act_c = ACT_HOLD;
			end
			ST_RUN: begin
				priority if (!mode_q[MODE_PIVOT]) begin
					left_c      = pow_n;
					right_c     = -pow_n;
					left_act_c  = ACT_SPIN;
					right_act_c = ACT_SPIN;
				end else if (mode_q[MODE_LEFT_HOLD]) begin
					right_c     = pow_v;
					left_act_c  = ACT_HOLD;
					right_act_c = ACT_SPIN;
				end else if (mode_q[MODE_RIGHT_HOLD]) begin
					left_c      = pow_v;
					left_act_c  = ACT_SPIN;
					right_act_c = ACT_HOLD;
				end else begin
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld5) begin
			left_s5      <= left_c;
			right_s5     <= right_c;
			left_act_s5  <= left_act_c;
			right_act_s5 <= right_act_c;
			status_s5    <= kind_s4;
		end
	end

	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata  = {4'b0, right_act_s5, left_act_s5, right_s5, left_s5};
	assign m_axis_tuser  = status_s5;

`ifndef ASSERT_OFF
	// a full pipeline behind a stalled receiver must refuse new samples
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && !m_axis_tready)
		|-> !s_axis_tready)
		else $error("input accepted while every stage is held");

	// a running sample leaves its error as the next sample's reference
	a_prev_err: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && kind_c == ST_RUN) |=> (prev_error_q == err_s2))
		else $error("previous error not taken from the sample just processed");

	// a timeout or settle ends the turn
	a_turn_end: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && (kind_c == ST_TIMEOUT || kind_c == ST_SETTLED)) |=> !running_q)
		else $error("turn still running after it ended");

	// only a running result may carry a nonzero drive
	a_quiet_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_RUN)
		|-> (m_axis_tdata[31:0] == 32'd0))
		else $error("drive value on a result that is not running");
`endif

endmodule
